/* sv/gaps_pkg.sv */
// Shared types, constants and helper functions for the grid path search block.
// No dependencies; the other files but gaps_ram refer to this package by scoped names.
`timescale 1ns / 1ps

package gaps_pkg;

  localparam int GRID_SIDE = 128;
  localparam int COORD_W   = 7;
  localparam int CELL_W    = 14;
  localparam int NCELLS    = GRID_SIDE * GRID_SIDE;
  localparam int CNT_W     = 15;
  localparam int COST_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int BIAS_W    = 20;
  localparam int GUESS_W   = 24;
  localparam int SQ_STEPS  = 24;
  localparam int V_W       = 2 * SQ_STEPS;
  localparam int D2_W      = 15;
  localparam int PROD_W    = GUESS_W + BIAS_W;
  localparam int MARK_W    = 2;

  localparam logic [COST_W-1:0] W_STR  = COST_W'(64'd1 << FRAC_BITS);
  localparam logic [COST_W-1:0] W_DIAG =
    COST_W'(((64'd141421 << FRAC_BITS) + 64'd50000) / 64'd100000);

  localparam logic [MARK_W-1:0] MARK_NONE   = 2'b00;
  localparam logic [MARK_W-1:0] MARK_OPEN   = 2'b01;
  localparam logic [MARK_W-1:0] MARK_CLOSED = 2'b10;

  localparam logic [2:0] CFG_START_X = 3'd0;
  localparam logic [2:0] CFG_START_Y = 3'd1;
  localparam logic [2:0] CFG_GOAL_X  = 3'd2;
  localparam logic [2:0] CFG_GOAL_Y  = 3'd3;
  localparam logic [2:0] CFG_BIAS    = 3'd4;

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_SEARCH = 2'd1,
    ACT_READ   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SWEEP, ST_INIT, ST_SCAN, ST_REMOVE, ST_CUR_RD, ST_CUR_EVAL,
    ST_NB_RD, ST_NB_EVAL, ST_SQRT, ST_MUL, ST_WRITE, ST_FIN_RD, ST_REPORT,
    ST_PATH
  } state_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [COORD_W-1:0] cell_col;
    logic [COORD_W-1:0] cell_row;
    logic               wall_bit;
  } in_item_t;

  typedef struct packed {
    logic               result_kind;
    logic               found;
    logic [COST_W-1:0]  cost_q16;
    logic [CNT_W-1:0]   expansions;
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
    logic               last_cell;
  } result_t;

  typedef struct packed {
    state_t op;
    logic   take;
  } dp_cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic coords_ok;
    logic count_zero;
    logic scan_done;
    logic shift_done;
    logic is_goal;
    logic cur_dead;
    logic nb_skip;
    logic nb_new;
    logic nb_last;
    logic sqrt_done;
    logic path_valid;
  } dp_stat_t;

  function automatic logic [CELL_W-1:0] cell_of(input logic [COORD_W-1:0] row,
                                                input logic [COORD_W-1:0] col);
    cell_of = {row, col};
  endfunction

  // neighbour order: four diagonals, then up/left/right/down straights
  function automatic logic [COORD_W-1:0] nb_col(input logic [COORD_W-1:0] x,
                                                input logic [2:0] i);
    if (i inside {3'd0, 3'd1, 3'd5}) nb_col = x - COORD_W'(1);
    else if (i inside {3'd2, 3'd3, 3'd6}) nb_col = x + COORD_W'(1);
    else nb_col = x;
  endfunction

  function automatic logic [COORD_W-1:0] nb_row(input logic [COORD_W-1:0] y,
                                                input logic [2:0] i);
    if (i inside {3'd0, 3'd2, 3'd4}) nb_row = y - COORD_W'(1);
    else if (i inside {3'd1, 3'd3, 3'd7}) nb_row = y + COORD_W'(1);
    else nb_row = y;
  endfunction

  function automatic logic [COST_W-1:0] sat_cost(input logic [COST_W:0] s);
    sat_cost = s[COST_W] ? '1 : s[COST_W-1:0];
  endfunction

endpackage

/* sv/gaps_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module gaps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

/* sv/gaps_ctrl.sv */
// Sequencer for the grid path search: state register and next-state logic.
// Depends on gaps_pkg.
`timescale 1ns / 1ps

module gaps_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        action,
  input  gaps_pkg::dp_stat_t stat,
  output gaps_pkg::dp_cmd_t  cmd,
  output logic              busy
);

  gaps_pkg::state_t state, state_next;
  logic take;

  assign take = start && (state == gaps_pkg::ST_IDLE);
  assign busy = (state != gaps_pkg::ST_IDLE);
  assign cmd  = '{op: state, take: take};

  always_ff @(posedge clk) begin
    if (rst) state <= gaps_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      gaps_pkg::ST_IDLE: begin
        if (take && action == gaps_pkg::ACT_SEARCH) state_next = gaps_pkg::ST_SWEEP;
        else if (take && action == gaps_pkg::ACT_READ && stat.path_valid)
          state_next = gaps_pkg::ST_PATH;
      end
      gaps_pkg::ST_SWEEP: begin
        if (stat.sweep_done)
          state_next = stat.coords_ok ? gaps_pkg::ST_INIT : gaps_pkg::ST_REPORT;
      end
      gaps_pkg::ST_INIT: state_next = gaps_pkg::ST_SCAN;
      gaps_pkg::ST_SCAN: begin
        if (stat.count_zero)     state_next = gaps_pkg::ST_REPORT;
        else if (stat.scan_done) state_next = gaps_pkg::ST_REMOVE;
      end
      gaps_pkg::ST_REMOVE: begin
        if (stat.shift_done)
          state_next = stat.is_goal ? gaps_pkg::ST_FIN_RD : gaps_pkg::ST_CUR_RD;
      end
      gaps_pkg::ST_CUR_RD: state_next = gaps_pkg::ST_CUR_EVAL;
      gaps_pkg::ST_CUR_EVAL:
        state_next = stat.cur_dead ? gaps_pkg::ST_SCAN : gaps_pkg::ST_NB_RD;
      gaps_pkg::ST_NB_RD: state_next = gaps_pkg::ST_NB_EVAL;
      gaps_pkg::ST_NB_EVAL: begin
        if (stat.nb_skip)
          state_next = stat.nb_last ? gaps_pkg::ST_SCAN : gaps_pkg::ST_NB_RD;
        else if (stat.nb_new) state_next = gaps_pkg::ST_SQRT;
        else                  state_next = gaps_pkg::ST_MUL;
      end
      gaps_pkg::ST_SQRT: if (stat.sqrt_done) state_next = gaps_pkg::ST_MUL;
      gaps_pkg::ST_MUL: state_next = gaps_pkg::ST_WRITE;
      gaps_pkg::ST_WRITE:
        state_next = stat.nb_last ? gaps_pkg::ST_SCAN : gaps_pkg::ST_NB_RD;
      gaps_pkg::ST_FIN_RD: state_next = gaps_pkg::ST_REPORT;
      gaps_pkg::ST_REPORT: state_next = gaps_pkg::ST_IDLE;
      gaps_pkg::ST_PATH:   state_next = gaps_pkg::ST_IDLE;
      default: state_next = gaps_pkg::ST_IDLE;
    endcase
  end

endmodule

/* sv/gaps_dp.sv */
// Datapath for the grid path search: configuration, cell memories, open list,
// scan/shift counters, square-root unit, cost arithmetic and result register.
// Depends on gaps_pkg and gaps_ram.
`timescale 1ns / 1ps

module gaps_dp (
  input  logic               clk,
  input  logic               rst,
  input  gaps_pkg::dp_cmd_t  cmd,
  input  gaps_pkg::in_item_t item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [19:0]        cfg_data,
  output gaps_pkg::dp_stat_t stat,
  output logic               result_valid,
  output gaps_pkg::result_t  result
);

  localparam int CW = gaps_pkg::CELL_W;
  localparam int XW = gaps_pkg::COORD_W;

  // configuration
  logic [XW-1:0] start_x, start_y, goal_x, goal_y;
  logic [gaps_pkg::BIAS_W-1:0] bias;

  // search state
  logic [gaps_pkg::CNT_W-1:0] open_count, expansions;
  logic found, path_valid;
  logic [CW-1:0] path_cursor, path_start, sweep_cnt;
  logic [gaps_pkg::CNT_W-1:0] si, rj;
  logic p1_v, p2_v, have_best, wv;
  logic [CW-1:0] p1_idx, p2_idx, p2_cell, best_idx, best_cell, wa;
  logic [gaps_pkg::COST_W-1:0] best_f, cur_g, nd_r;
  logic [2:0] nb_i;
  logic [CW-1:0] nb_cell;
  logic [XW-1:0] nb_col_r, nb_row_r;
  logic is_new;
  logic [gaps_pkg::GUESS_W-1:0] guess_r, guess_wr, guess_use;
  logic [gaps_pkg::V_W-1:0] sq_v, sq_r, sq_bit, sq_t, sq_h;
  logic [4:0] sq_n;
  logic [gaps_pkg::PROD_W-1:0] prod;

  // combinational helpers
  logic [CW-1:0] s_cell, g_cell, nb_c;
  logic [XW-1:0] cur_col, cur_row, dx, dy;
  logic [gaps_pkg::D2_W-1:0] d2;
  logic [gaps_pkg::COST_W-1:0] nd_c, tot_c;
  logic take_read;

  // memory ports
  logic wall_we, wall_rdata, wall_wdata;
  logic [CW-1:0] wall_waddr, wall_raddr;
  logic mark_we;
  logic [gaps_pkg::MARK_W-1:0] mark_wdata, mark_rdata;
  logic [CW-1:0] mark_waddr;
  logic reach_we;
  logic [gaps_pkg::COST_W-1:0] reach_wdata, reach_rdata;
  logic [CW-1:0] reach_waddr, reach_raddr;
  logic guess_we;
  logic [gaps_pkg::GUESS_W-1:0] guess_wdata, guess_rdata;
  logic [CW-1:0] guess_waddr;
  logic total_we;
  logic [gaps_pkg::COST_W-1:0] total_wdata, total_rdata;
  logic [CW-1:0] total_waddr;
  logic link_we;
  logic [CW-1:0] link_waddr, link_wdata, link_rdata;
  logic queue_we;
  logic [CW-1:0] queue_waddr, queue_wdata, queue_raddr, queue_rdata;

  assign cfg_ready = 1'b1;
  assign s_cell  = gaps_pkg::cell_of(start_y, start_x);
  assign g_cell  = gaps_pkg::cell_of(goal_y, goal_x);
  assign cur_col = best_cell[XW-1:0];
  assign cur_row = best_cell[CW-1:XW];
  assign nb_c    = gaps_pkg::cell_of(gaps_pkg::nb_row(cur_row, nb_i),
                                     gaps_pkg::nb_col(cur_col, nb_i));
  assign dx = (nb_col_r >= goal_x) ? nb_col_r - goal_x : goal_x - nb_col_r;
  assign dy = (nb_row_r >= goal_y) ? nb_row_r - goal_y : goal_y - nb_row_r;
  assign d2 = gaps_pkg::D2_W'(dx * dx) + gaps_pkg::D2_W'(dy * dy);
  assign nd_c = gaps_pkg::sat_cost({1'b0, cur_g} +
                  {1'b0, (nb_i < 3'd4) ? gaps_pkg::W_DIAG : gaps_pkg::W_STR});
  assign tot_c = gaps_pkg::sat_cost({1'b0, nd_r} +
                  (gaps_pkg::COST_W + 1)'(prod >> gaps_pkg::FRAC_BITS));
  assign sq_t = sq_r + sq_bit;
  // round to nearest: bump when the remainder exceeds the root
  assign sq_h = sq_r + ((sq_v > sq_r) ? gaps_pkg::V_W'(1) : '0);
  assign guess_use = is_new ? sq_h[gaps_pkg::GUESS_W-1:0] : guess_r;
  assign take_read = cmd.take && item.action == gaps_pkg::ACT_READ && path_valid;

  always_comb begin
    stat.sweep_done = (sweep_cnt == CW'(gaps_pkg::NCELLS - 1));
    stat.coords_ok  = int'(start_x) < gaps_pkg::GRID_SIDE &&
                      int'(start_y) < gaps_pkg::GRID_SIDE &&
                      int'(goal_x) < gaps_pkg::GRID_SIDE &&
                      int'(goal_y) < gaps_pkg::GRID_SIDE;
    stat.count_zero = (open_count == '0);
    stat.scan_done  = (si == open_count) && !p1_v && !p2_v;
    stat.shift_done = (rj >= open_count) && !wv;
    stat.is_goal    = (best_cell == g_cell);
    stat.cur_dead   = wall_rdata || cur_col == '0 || cur_row == '0 ||
                      int'(cur_col) > gaps_pkg::GRID_SIDE - 2 ||
                      int'(cur_row) > gaps_pkg::GRID_SIDE - 2;
    stat.nb_skip    = wall_rdata || mark_rdata[1] ||
                      (mark_rdata[0] && nd_c >= reach_rdata);
    stat.nb_new     = !mark_rdata[0];
    stat.nb_last    = (nb_i == 3'd7);
    stat.sqrt_done  = (sq_n == 5'(gaps_pkg::SQ_STEPS));
    stat.path_valid = path_valid;
  end

  // memory port steering
  always_comb begin
    wall_we    = cmd.take && item.action == gaps_pkg::ACT_WRITE &&
                 int'(item.cell_col) < gaps_pkg::GRID_SIDE &&
                 int'(item.cell_row) < gaps_pkg::GRID_SIDE;
    wall_waddr = gaps_pkg::cell_of(item.cell_row, item.cell_col);
    wall_wdata = item.wall_bit;
    wall_raddr = (cmd.op == gaps_pkg::ST_CUR_RD) ? best_cell : nb_c;

    mark_we = 1'b0; mark_waddr = nb_cell; mark_wdata = gaps_pkg::MARK_OPEN;
    reach_we = 1'b0; reach_waddr = nb_cell; reach_wdata = nd_r;
    guess_we = 1'b0; guess_waddr = nb_cell; guess_wdata = guess_wr;
    total_we = 1'b0; total_waddr = nb_cell; total_wdata = tot_c;
    link_we = 1'b0;  link_waddr = nb_cell;  link_wdata = best_cell;
    queue_we = 1'b0; queue_waddr = open_count[CW-1:0]; queue_wdata = nb_cell;
    reach_raddr = nb_c;
    queue_raddr = si[CW-1:0];

    case (cmd.op)
      gaps_pkg::ST_SWEEP: begin
        mark_we = 1'b1; mark_waddr = sweep_cnt; mark_wdata = gaps_pkg::MARK_NONE;
      end
      gaps_pkg::ST_INIT: begin
        mark_we  = 1'b1; mark_waddr  = s_cell;
        reach_we = 1'b1; reach_waddr = s_cell; reach_wdata = '0;
        guess_we = 1'b1; guess_waddr = s_cell; guess_wdata = '0;
        total_we = 1'b1; total_waddr = s_cell; total_wdata = '0;
        link_we  = 1'b1; link_waddr  = s_cell; link_wdata  = s_cell;
        queue_we = 1'b1; queue_waddr = '0;     queue_wdata = s_cell;
      end
      gaps_pkg::ST_REMOVE: begin
        queue_raddr = rj[CW-1:0];
        queue_we    = wv; queue_waddr = wa; queue_wdata = queue_rdata;
        mark_we     = (rj >= open_count) && !wv;
        mark_waddr  = best_cell; mark_wdata = gaps_pkg::MARK_CLOSED;
      end
      gaps_pkg::ST_CUR_RD, gaps_pkg::ST_FIN_RD: reach_raddr = best_cell;
      gaps_pkg::ST_WRITE: begin
        reach_we = 1'b1; total_we = 1'b1; link_we = 1'b1;
        mark_we = is_new; guess_we = is_new; queue_we = is_new;
      end
      default: ;
    endcase
  end

  gaps_ram #(.WIDTH(1), .DEPTH(gaps_pkg::NCELLS)) u_wall (
    .clk, .we(wall_we), .waddr(wall_waddr), .wdata(wall_wdata),
    .raddr(wall_raddr), .rdata(wall_rdata));
  gaps_ram #(.WIDTH(gaps_pkg::MARK_W), .DEPTH(gaps_pkg::NCELLS)) u_mark (
    .clk, .we(mark_we), .waddr(mark_waddr), .wdata(mark_wdata),
    .raddr(nb_c), .rdata(mark_rdata));
  gaps_ram #(.WIDTH(gaps_pkg::COST_W), .DEPTH(gaps_pkg::NCELLS)) u_reach (
    .clk, .we(reach_we), .waddr(reach_waddr), .wdata(reach_wdata),
    .raddr(reach_raddr), .rdata(reach_rdata));
  gaps_ram #(.WIDTH(gaps_pkg::GUESS_W), .DEPTH(gaps_pkg::NCELLS)) u_guess (
    .clk, .we(guess_we), .waddr(guess_waddr), .wdata(guess_wdata),
    .raddr(nb_c), .rdata(guess_rdata));
  gaps_ram #(.WIDTH(gaps_pkg::COST_W), .DEPTH(gaps_pkg::NCELLS)) u_total (
    .clk, .we(total_we), .waddr(total_waddr), .wdata(total_wdata),
    .raddr(queue_rdata), .rdata(total_rdata));
  gaps_ram #(.WIDTH(CW), .DEPTH(gaps_pkg::NCELLS)) u_link (
    .clk, .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(path_cursor), .rdata(link_rdata));
  gaps_ram #(.WIDTH(CW), .DEPTH(gaps_pkg::NCELLS)) u_queue (
    .clk, .we(queue_we), .waddr(queue_waddr), .wdata(queue_wdata),
    .raddr(queue_raddr), .rdata(queue_rdata));

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_x <= '0; start_y <= '0; goal_x <= '0; goal_y <= '0;
      bias <= gaps_pkg::BIAS_W'(65536);
      open_count <= '0; expansions <= '0; found <= 1'b0;
      path_valid <= 1'b0; path_cursor <= '0; path_start <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          gaps_pkg::CFG_START_X: start_x <= cfg_data[XW-1:0];
          gaps_pkg::CFG_START_Y: start_y <= cfg_data[XW-1:0];
          gaps_pkg::CFG_GOAL_X:  goal_x  <= cfg_data[XW-1:0];
          gaps_pkg::CFG_GOAL_Y:  goal_y  <= cfg_data[XW-1:0];
          gaps_pkg::CFG_BIAS:    bias    <= cfg_data;
          default: ;
        endcase
      end
      case (cmd.op)
        gaps_pkg::ST_IDLE: begin
          if (take_read) begin
            result_valid <= 1'b1;
            if (path_cursor == path_start) path_valid <= 1'b0;
          end
        end
        gaps_pkg::ST_SWEEP: begin
          open_count <= '0; expansions <= '0; found <= 1'b0; path_valid <= 1'b0;
        end
        gaps_pkg::ST_INIT: open_count <= gaps_pkg::CNT_W'(1);
        gaps_pkg::ST_REMOVE: begin
          if ((rj >= open_count) && !wv) begin
            open_count <= open_count - 1'b1;
            expansions <= expansions + 1'b1;
            found      <= (best_cell == g_cell);
          end
        end
        gaps_pkg::ST_WRITE: if (is_new) open_count <= open_count + 1'b1;
        gaps_pkg::ST_REPORT: begin
          result_valid <= 1'b1;
          if (found) begin
            path_valid <= 1'b1; path_cursor <= g_cell; path_start <= s_cell;
          end
        end
        gaps_pkg::ST_PATH: if (path_valid) path_cursor <= link_rdata;
        default: ;
      endcase
    end
  end

  // work registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0; si <= '0; p1_v <= 1'b0; p2_v <= 1'b0; have_best <= 1'b0;
      rj <= '0; wv <= 1'b0; nb_i <= '0; sq_n <= '0;
    end else begin
      sweep_cnt <= (cmd.op == gaps_pkg::ST_SWEEP) ? sweep_cnt + 1'b1 : '0;

      // open-list scan: queue read, then total-cost read, then compare
      if (cmd.op == gaps_pkg::ST_SCAN) begin
        if (si < open_count) begin
          si <= si + 1'b1; p1_v <= 1'b1; p1_idx <= si[CW-1:0];
        end else p1_v <= 1'b0;
        p2_v <= p1_v; p2_idx <= p1_idx; p2_cell <= queue_rdata;
        if (p2_v && (!have_best || total_rdata < best_f)) begin
          have_best <= 1'b1; best_f <= total_rdata;
          best_idx <= p2_idx; best_cell <= p2_cell;
        end
      end else begin
        si <= '0; p1_v <= 1'b0; p2_v <= 1'b0; have_best <= 1'b0;
      end

      // close the gap left by the taken entry
      if (cmd.op == gaps_pkg::ST_REMOVE) begin
        if (rj < open_count) begin
          rj <= rj + 1'b1; wv <= 1'b1; wa <= rj[CW-1:0] - 1'b1;
        end else wv <= 1'b0;
      end else begin
        rj <= {1'b0, best_idx} + 1'b1; wv <= 1'b0;
      end

      case (cmd.op)
        gaps_pkg::ST_CUR_EVAL: begin
          cur_g <= reach_rdata; nb_i <= '0;
        end
        gaps_pkg::ST_NB_RD: begin
          nb_cell  <= nb_c;
          nb_col_r <= gaps_pkg::nb_col(cur_col, nb_i);
          nb_row_r <= gaps_pkg::nb_row(cur_row, nb_i);
        end
        gaps_pkg::ST_NB_EVAL: begin
          nd_r <= nd_c; is_new <= !mark_rdata[0]; guess_r <= guess_rdata;
          if (stat.nb_skip) nb_i <= nb_i + 1'b1;
        end
        gaps_pkg::ST_MUL: begin
          prod     <= guess_use * bias;
          guess_wr <= guess_use;
        end
        gaps_pkg::ST_WRITE: nb_i <= nb_i + 1'b1;
        default: ;
      endcase

      // square root, one result bit per step from two bits of the radicand
      if (cmd.op == gaps_pkg::ST_SQRT) begin
        if (sq_n != 5'(gaps_pkg::SQ_STEPS)) begin
          if (sq_v >= sq_t) begin
            sq_v <= sq_v - sq_t; sq_r <= (sq_r >> 1) + sq_bit;
          end else sq_r <= sq_r >> 1;
          sq_bit <= sq_bit >> 2;
          sq_n   <= sq_n + 1'b1;
        end
      end else if (cmd.op != gaps_pkg::ST_MUL) begin
        sq_v   <= gaps_pkg::V_W'(d2) << (2 * gaps_pkg::FRAC_BITS);
        sq_r   <= '0;
        sq_bit <= gaps_pkg::V_W'(1) << (gaps_pkg::V_W - 2);
        sq_n   <= '0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.op == gaps_pkg::ST_REPORT) begin
      result <= '{result_kind: 1'b0, found: found,
                  cost_q16: found ? reach_rdata : '0, expansions: expansions,
                  out_col: '0, out_row: '0, last_cell: 1'b0};
    end else if (take_read) begin
      result <= '{result_kind: 1'b1, found: 1'b0, cost_q16: '0, expansions: '0,
                  out_col: path_cursor[XW-1:0], out_row: path_cursor[CW-1:XW],
                  last_cell: path_cursor == path_start};
    end
  end

endmodule

/* sv/grid_astar_path_search.sv */
// A* path search over a 128 x 128 8-connected wall map. Top level: sequencer
// and datapath. Depends on gaps_pkg, gaps_ctrl, gaps_dp.
`timescale 1ns / 1ps

// Commands are taken when start is high and busy low. A map write is done
// as it is taken. A path read goes through the path state, where the back-link
// memory read sets the next cell. A search first sweeps every entry of the
// open/closed mark memory, then per expansion scans the open list for the lowest
// f, closes the list over the entries behind the taken one, fetches the cell,
// and per neighbour reads and evaluates it, updates it, and first runs the
// square-root unit when the cell is new to the list. Each result beat is shown
// for exactly one cycle on result_valid; the receiver cannot stall, so it must
// take every beat. Configuration is always ready.
module grid_astar_path_search (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  gaps_pkg::in_item_t item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [19:0]        cfg_data,
  output logic               result_valid,
  output gaps_pkg::result_t  result
);

  gaps_pkg::dp_cmd_t  cmd;
  gaps_pkg::dp_stat_t stat;

  gaps_ctrl u_ctrl (
    .clk, .rst, .start, .action(item.action), .stat, .cmd, .busy);

  gaps_dp u_dp (
    .clk, .rst, .cmd, .item, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .stat, .result_valid, .result);

  a_search_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.action == gaps_pkg::ACT_SEARCH) |=> busy)
    else $error("search command did not start");

  a_cell_beat_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.result_kind) |->
      (!result.found && result.cost_q16 == '0 && result.expansions == '0))
    else $error("path cell beat carries summary fields");

  a_miss_zero_cost: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.result_kind && !result.found) |->
      (result.cost_q16 == '0))
    else $error("not-found summary with non-zero cost");

  a_summary_after_busy: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.result_kind) |-> $past(busy))
    else $error("summary beat without a search");

endmodule
